// ===== hw/rtl/srr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srr_pkg
// Shared widths and codes of the segment SDU reassembler.
// ----------------------------------------------------------------------------
package srr_pkg;

    localparam int TYPE_W  = 2;
    localparam int SEQ_W   = 16;
    localparam int OFF_W   = 6;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 7;
    localparam int STAT_W  = 2;
    localparam int DCNT_W  = 16;
    localparam int META_W  = OFF_W + LEN_W;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;

    typedef enum logic [TYPE_W-1:0] {
        SEG_FULL   = 2'd0,
        SEG_FIRST  = 2'd1,
        SEG_LAST   = 2'd2,
        SEG_MIDDLE = 2'd3
    } t_seg_type;

    typedef enum logic [STAT_W-1:0] {
        ST_SDU_BYTE = 2'd0,
        ST_STORED   = 2'd1,
        ST_NO_SLOT  = 2'd2,
        ST_NO_ROOM  = 2'd3
    } t_status;

endpackage

// ===== hw/rtl/srr_staging.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srr_staging
// Staging buffer: collects the bytes of the segment in flight and reports
// its length on the closing byte.
// ----------------------------------------------------------------------------
module srr_staging #(
    parameter int MAX_SDU_BYTES = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr,
    input  logic [srr_pkg::BYTE_W-1:0] i_byte,
    input  logic                       i_eos,
    output logic [srr_pkg::LEN_W-1:0]  o_len,
    input  logic                       i_rd,
    input  logic [$clog2(MAX_SDU_BYTES)-1:0] i_rd_idx,
    output logic [srr_pkg::BYTE_W-1:0] o_rd_data
);
    import srr_pkg::*;

    localparam int JW = $clog2(MAX_SDU_BYTES);
    localparam int CW = $clog2(MAX_SDU_BYTES + 2);

    logic [BYTE_W-1:0] r_mem [MAX_SDU_BYTES];
    logic [CW-1:0]     r_count;
    logic [BYTE_W-1:0] r_rd_data;
    logic              full;

    assign full      = r_count >= CW'(MAX_SDU_BYTES);
    assign o_len     = full ? LEN_W'(MAX_SDU_BYTES + 1) : LEN_W'(r_count) + LEN_W'(1);
    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr && !full) begin
            r_mem[r_count[JW-1:0]] <= i_byte;
        end
        if (i_rd) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_wr) begin
            if (i_eos) begin
                r_count <= '0;
            end else if (!full) begin
                r_count <= r_count + CW'(1);
            end else begin
                // saturate one above the limit so the segment drops
                r_count <= CW'(MAX_SDU_BYTES + 1);
            end
        end
    end

endmodule

// ===== hw/rtl/srr_byte_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srr_byte_store
// Segment byte memory, one row of MAX_SDU_BYTES per segment entry.
// ----------------------------------------------------------------------------
module srr_byte_store #(
    parameter int SDU_SLOTS     = 4,
    parameter int SEGS_PER_SDU  = 8,
    parameter int MAX_SDU_BYTES = 64,
    parameter int EA_W          = 5
) (
    input  logic                       i_clk,
    input  logic                       i_wr,
    input  logic [EA_W-1:0]            i_wr_ent,
    input  logic [$clog2(MAX_SDU_BYTES)-1:0] i_wr_idx,
    input  logic [srr_pkg::BYTE_W-1:0] i_wr_data,
    input  logic                       i_rd,
    input  logic [EA_W-1:0]            i_rd_ent,
    input  logic [$clog2(MAX_SDU_BYTES)-1:0] i_rd_idx,
    output logic [srr_pkg::BYTE_W-1:0] o_rd_data
);
    import srr_pkg::*;

    localparam int JW    = $clog2(MAX_SDU_BYTES);
    localparam int AW    = EA_W + JW;
    localparam int DEPTH = 1 << AW;

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[{i_wr_ent, i_wr_idx}] <= i_wr_data;
        end
        if (i_rd) begin
            r_rd_data <= r_mem[{i_rd_ent, i_rd_idx}];
        end
    end

endmodule

// ===== hw/rtl/segment_sdu_reassembler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_sdu_reassembler
// Reassembles SDUs from tagged segment bytes and streams out whole SDUs.
// ----------------------------------------------------------------------------
// Slave stream: one segment byte per transfer; tuser is the segment type,
// tlast closes the segment. Tags are taken from the closing byte.
// Master stream: one result per transfer; tuser is the status (SDU byte,
// segment stored, dropped for lack of a slot, dropped for lack of room),
// tlast marks the last result caused by one segment.
// A non-closing byte is written into staging while the block is idle. A
// closing byte holds the input while the segment is stored (lookup, entry
// choice, staging copy at one byte a cycle, copy end, check), then during
// the tiling walk over the stored segments. A delivery reads and sends each
// SDU byte in turn, steps to each next segment and then frees the slot;
// otherwise a status result follows. A drop ends with a status result.
// tready on the slave side is low while a segment is committed or an SDU
// is streamed out. A result waits in the output register while the
// receiver stalls; the block stalls behind it.
// Reset clears slot and entry valid flags, the staging count and the
// delivery counter; memories are not cleared.
// ----------------------------------------------------------------------------
module segment_sdu_reassembler #(
    parameter int SDU_SLOTS     = 4,
    parameter int SEGS_PER_SDU  = 8,
    parameter int MAX_SDU_BYTES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // seq_number[15:0], seg_start[21:16], data_byte[29:22], zero pad
    input  logic [srr_pkg::S_TDATA_W-1:0] i_s_tdata,
    // seg_type[1:0]
    input  logic [srr_pkg::TYPE_W-1:0]    i_s_tuser,
    input  logic                          i_s_tlast,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // sdu_seq[15:0], sdu_byte[23:16], delivered_total[39:24]
    output logic [srr_pkg::M_TDATA_W-1:0] o_m_tdata,
    // status[1:0]
    output logic [srr_pkg::STAT_W-1:0]    o_m_tuser,
    output logic                          o_m_tlast
);
    import srr_pkg::*;

    localparam int SW   = (SDU_SLOTS > 1) ? $clog2(SDU_SLOTS) : 1;
    localparam int EW   = (SEGS_PER_SDU > 1) ? $clog2(SEGS_PER_SDU) : 1;
    localparam int JW   = $clog2(MAX_SDU_BYTES);
    localparam int CNTW = $clog2(SEGS_PER_SDU + 1);
    localparam int SUMW = LEN_W + 1;

    typedef logic [SEGS_PER_SDU-1:0][META_W-1:0] t_row;
    typedef logic [SEGS_PER_SDU-1:0]             t_vrow;

    typedef enum logic [3:0] {
        S_IDLE, S_LOOKUP, S_META, S_COPY, S_COPY_END, S_CHECK,
        S_WALK, S_FIND, S_RDB, S_OUTB, S_FREE, S_STAT
    } t_state;

    // ------------------------------------------------------------------
    // registers
    t_state              r_state;
    logic [SEQ_W-1:0]    r_seq;
    logic [OFF_W-1:0]    r_off;
    t_seg_type           r_type;
    logic [LEN_W-1:0]    r_len;
    logic                r_too_long;
    logic [SW-1:0]       r_slot;
    logic                r_new;
    logic [EW-1:0]       r_ent_e;
    logic [JW-1:0]       r_j;
    logic [JW-1:0]       r_wj;
    logic                r_wv;
    logic [LEN_W-1:0]    r_cur;
    logic [CNTW-1:0]     r_used;
    logic [LEN_W-1:0]    r_elen;
    t_status             r_stat;
    t_row                r_row;
    t_row                r_meta_mem [SDU_SLOTS];
    t_row                r_meta_rd;
    logic [DCNT_W-1:0]   r_dcount;

    logic [SDU_SLOTS-1:0]             r_slot_valid;
    logic [SEQ_W-1:0]                 r_slot_seq   [SDU_SLOTS];
    logic [SDU_SLOTS-1:0]             r_slot_first;
    logic [SDU_SLOTS-1:0]             r_slot_last;
    logic [LEN_W-1:0]                 r_slot_total [SDU_SLOTS];
    t_vrow                            r_ent_valid  [SDU_SLOTS];

    logic                r_out_valid;
    t_status             r_o_stat;
    logic [SEQ_W-1:0]    r_o_seq;
    logic [BYTE_W-1:0]   r_o_byte;
    logic                r_o_last;
    logic [DCNT_W-1:0]   r_o_total;

    // ------------------------------------------------------------------
    // combinational
    logic                in_acc;
    logic                out_free;
    logic                out_load;
    logic [LEN_W-1:0]    stg_len;
    logic [BYTE_W-1:0]   stg_rd_data;
    logic [BYTE_W-1:0]   bs_rd_data;
    logic [SUMW-1:0]     end_sum;

    logic [SDU_SLOTS-1:0] slot_match;
    logic                 slot_found;
    logic [SW-1:0]        slot_idx;
    logic                 free_found;
    logic [SW-1:0]        free_idx;

    t_vrow               meta_v;
    logic [EW:0]         meta_hit;
    logic [EW:0]         meta_free;
    logic [EW-1:0]       meta_ent;
    t_row                meta_new_row;
    t_vrow               meta_new_v;
    logic                meta_first;
    logic                meta_last;
    logic [LEN_W-1:0]    meta_total;

    t_vrow               walk_v;
    logic [EW:0]         walk_hit;
    logic [CNTW-1:0]     walk_nvalid;
    logic [LEN_W-1:0]    walk_len;
    logic                seg_end;
    logic                sdu_end;

    function automatic logic [EW:0] f_find(input t_vrow v, input t_row row,
                                           input logic [LEN_W-1:0] key);
        logic [EW:0] res;
        res = '0;
        for (int e = SEGS_PER_SDU - 1; e >= 0; e--) begin
            if (v[e] && ({1'b0, row[e][OFF_W-1:0]} == key)) begin
                res = {1'b1, EW'(e)};
            end
        end
        return res;
    endfunction

    function automatic logic [EW:0] f_free(input t_vrow v);
        logic [EW:0] res;
        res = '0;
        for (int e = SEGS_PER_SDU - 1; e >= 0; e--) begin
            if (!v[e]) begin
                res = {1'b1, EW'(e)};
            end
        end
        return res;
    endfunction

    assign in_acc     = i_s_tvalid && (r_state == S_IDLE);
    assign o_s_tready = (r_state == S_IDLE);
    assign out_free   = !r_out_valid || i_m_tready;
    assign out_load   = out_free && ((r_state == S_OUTB) || (r_state == S_STAT));
    assign end_sum    = SUMW'(i_s_tdata[21:16]) + SUMW'(stg_len);

    // slot lookup, lowest match and lowest free
    always_comb begin
        slot_found = 1'b0;
        slot_idx   = '0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int s = SDU_SLOTS - 1; s >= 0; s--) begin
            slot_match[s] = r_slot_valid[s] && (r_slot_seq[s] == r_seq);
            if (slot_match[s]) begin
                slot_found = 1'b1;
                slot_idx   = SW'(s);
            end
            if (!r_slot_valid[s]) begin
                free_found = 1'b1;
                free_idx   = SW'(s);
            end
        end
    end

    // segment entry choice and slot update on commit
    always_comb begin
        meta_v       = r_new ? '0 : r_ent_valid[r_slot];
        meta_hit     = f_find(meta_v, r_meta_rd, {1'b0, r_off});
        meta_free    = f_free(meta_v);
        meta_ent     = meta_hit[EW] ? meta_hit[EW-1:0] : meta_free[EW-1:0];
        meta_new_row = r_meta_rd;
        meta_new_row[meta_ent] = {r_len, r_off};
        meta_new_v   = meta_v;
        meta_new_v[meta_ent] = 1'b1;
        meta_first   = (!r_new && r_slot_first[r_slot]) ||
                       (r_type == SEG_FULL) || (r_type == SEG_FIRST);
        meta_last    = (!r_new && r_slot_last[r_slot]) ||
                       (r_type == SEG_FULL) || (r_type == SEG_LAST);
        meta_total   = r_new ? '0 : r_slot_total[r_slot];
        if ((r_type == SEG_FULL) || (r_type == SEG_LAST)) begin
            meta_total = LEN_W'(r_off) + r_len;
        end
    end

    // tiling walk and delivery
    always_comb begin
        walk_v      = r_ent_valid[r_slot];
        walk_hit    = f_find(walk_v, r_row, r_cur);
        walk_nvalid = CNTW'($countones(walk_v));
        walk_len    = r_row[walk_hit[EW-1:0]][META_W-1:OFF_W];
        seg_end     = (LEN_W'(r_j) + LEN_W'(1)) == r_elen;
        sdu_end     = seg_end && ((r_cur + r_elen) == r_slot_total[r_slot]);
    end

    // ------------------------------------------------------------------
    srr_staging #(
        .MAX_SDU_BYTES (MAX_SDU_BYTES)
    ) u_staging (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (in_acc),
        .i_byte    (i_s_tdata[29:22]),
        .i_eos     (i_s_tlast),
        .o_len     (stg_len),
        .i_rd      (r_state == S_COPY),
        .i_rd_idx  (r_j),
        .o_rd_data (stg_rd_data)
    );

    srr_byte_store #(
        .SDU_SLOTS     (SDU_SLOTS),
        .SEGS_PER_SDU  (SEGS_PER_SDU),
        .MAX_SDU_BYTES (MAX_SDU_BYTES),
        .EA_W          (SW + EW)
    ) u_byte_store (
        .i_clk     (i_clk),
        .i_wr      (r_wv),
        .i_wr_ent  ({r_slot, r_ent_e}),
        .i_wr_idx  (r_wj),
        .i_wr_data (stg_rd_data),
        .i_rd      (r_state == S_RDB),
        .i_rd_ent  ({r_slot, r_ent_e}),
        .i_rd_idx  (r_j),
        .o_rd_data (bs_rd_data)
    );

    // segment metadata memory
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOOKUP) begin
            r_meta_rd <= r_meta_mem[slot_found ? slot_idx : free_idx];
        end
        if ((r_state == S_META) && (meta_hit[EW] || meta_free[EW])) begin
            r_meta_mem[r_slot] <= meta_new_row;
        end
    end

    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_slot_valid <= '0;
            r_slot_first <= '0;
            r_slot_last  <= '0;
            for (int s = 0; s < SDU_SLOTS; s++) begin
                r_slot_total[s] <= '0;
                r_ent_valid[s]  <= '0;
            end
            r_dcount    <= '0;
            r_out_valid <= 1'b0;
            r_wv        <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            r_wv <= (r_state == S_COPY);
            r_wj <= r_j;

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && i_s_tlast) begin
                        r_seq      <= i_s_tdata[15:0];
                        r_off      <= i_s_tdata[21:16];
                        r_type     <= t_seg_type'(i_s_tuser);
                        r_len      <= stg_len;
                        r_too_long <= (stg_len > LEN_W'(MAX_SDU_BYTES)) ||
                                      (end_sum > SUMW'(MAX_SDU_BYTES));
                        r_state    <= S_LOOKUP;
                    end
                end
                S_LOOKUP: begin
                    if (r_too_long) begin
                        r_stat  <= ST_NO_ROOM;
                        r_state <= S_STAT;
                    end else if (!slot_found && !free_found) begin
                        r_stat  <= ST_NO_SLOT;
                        r_state <= S_STAT;
                    end else begin
                        r_slot  <= slot_found ? slot_idx : free_idx;
                        r_new   <= !slot_found;
                        r_state <= S_META;
                    end
                end
                S_META: begin
                    if (!meta_hit[EW] && !meta_free[EW]) begin
                        r_stat  <= ST_NO_ROOM;
                        r_state <= S_STAT;
                    end else begin
                        r_slot_valid[r_slot] <= 1'b1;
                        r_slot_seq[r_slot]   <= r_seq;
                        r_slot_first[r_slot] <= meta_first;
                        r_slot_last[r_slot]  <= meta_last;
                        r_slot_total[r_slot] <= meta_total;
                        r_ent_valid[r_slot]  <= meta_new_v;
                        r_row                <= meta_new_row;
                        r_ent_e              <= meta_ent;
                        r_j                  <= '0;
                        r_state              <= S_COPY;
                    end
                end
                S_COPY: begin
                    // staging read now, byte store write next cycle
                    if (LEN_W'(r_j) == (r_len - LEN_W'(1))) begin
                        r_state <= S_COPY_END;
                    end else begin
                        r_j <= r_j + JW'(1);
                    end
                end
                S_COPY_END: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_cur  <= '0;
                    r_used <= '0;
                    if (r_slot_first[r_slot] && r_slot_last[r_slot]) begin
                        r_state <= S_WALK;
                    end else begin
                        r_stat  <= ST_STORED;
                        r_state <= S_STAT;
                    end
                end
                S_WALK: begin
                    if (r_used == walk_nvalid) begin
                        if ((r_cur == r_slot_total[r_slot]) && (r_cur != '0)) begin
                            r_dcount <= r_dcount + DCNT_W'(1);
                            r_cur    <= '0;
                            r_state  <= S_FIND;
                        end else begin
                            r_stat  <= ST_STORED;
                            r_state <= S_STAT;
                        end
                    end else if (!walk_hit[EW]) begin
                        r_stat  <= ST_STORED;
                        r_state <= S_STAT;
                    end else begin
                        r_cur  <= r_cur + walk_len;
                        r_used <= r_used + CNTW'(1);
                    end
                end
                S_FIND: begin
                    if (walk_hit[EW] && (r_cur < r_slot_total[r_slot])) begin
                        r_ent_e <= walk_hit[EW-1:0];
                        r_elen  <= walk_len;
                        r_j     <= '0;
                        r_state <= S_RDB;
                    end else begin
                        r_state <= S_FREE;
                    end
                end
                S_RDB: begin
                    r_state <= S_OUTB;
                end
                S_OUTB: begin
                    if (out_free) begin
                        r_o_stat    <= ST_SDU_BYTE;
                        r_o_seq     <= r_seq;
                        r_o_byte    <= bs_rd_data;
                        r_o_last    <= sdu_end;
                        r_o_total   <= r_dcount;
                        if (sdu_end) begin
                            r_state <= S_FREE;
                        end else if (seg_end) begin
                            r_cur   <= r_cur + r_elen;
                            r_state <= S_FIND;
                        end else begin
                            r_j     <= r_j + JW'(1);
                            r_state <= S_RDB;
                        end
                    end
                end
                S_FREE: begin
                    r_slot_valid[r_slot] <= 1'b0;
                    r_ent_valid[r_slot]  <= '0;
                    r_state              <= S_IDLE;
                end
                S_STAT: begin
                    if (out_free) begin
                        r_o_stat    <= r_stat;
                        r_o_seq     <= r_seq;
                        r_o_byte    <= '0;
                        r_o_last    <= 1'b1;
                        r_o_total   <= r_dcount;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_o_total, r_o_byte, r_o_seq};
    assign o_m_tuser  = r_o_stat;
    assign o_m_tlast  = r_o_last;

    // ------------------------------------------------------------------
    a_seq_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(slot_match))
        else $error("two valid slots hold the same sequence number");

    a_dcount_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_WALK) |=> (r_dcount == $past(r_dcount)))
        else $error("delivery count moved outside the tiling walk");

    a_copy_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_wv)
        else $error("byte store write pending while idle");

    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUTB) && !out_free) |=> (r_state == S_OUTB))
        else $error("SDU byte dropped while output stalled");

endmodule
